>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hw/rtl/cpr_pkg.sv
// Shared constants, codes and types of the CLOCK-Pro replacement block.
// No dependencies.
package cpr_pkg;

  localparam int MAX_PAGES  = 128;
  localparam int SLOT_COUNT = 256;
  localparam int PAGE_BITS  = 32;
  localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
  localparam int PTR_W      = SLOT_BITS + 1;
  localparam int LIM_W      = 8;
  localparam int DATA_W     = 32;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [PAGE_BITS-1:0] page_t;

  localparam ptr_t NIL = ptr_t'(SLOT_COUNT);

  // List codes.
  localparam logic [1:0] L_COLD = 2'd0;
  localparam logic [1:0] L_HOT  = 2'd1;
  localparam logic [1:0] L_TEST = 2'd2;

  // Slot status codes.
  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_COLD = 2'd1;
  localparam logic [1:0] ST_HOT  = 2'd2;
  localparam logic [1:0] ST_TEST = 2'd3;

  // Outcome codes.
  localparam logic [1:0] OC_COLD_HIT = 2'd0;
  localparam logic [1:0] OC_HOT_HIT  = 2'd1;
  localparam logic [1:0] OC_TEST_HIT = 2'd2;
  localparam logic [1:0] OC_MISS     = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_RD, S_EXEC, S_APP1, S_APP2,
    S_ROOM, S_TRIM, S_FILL, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_PROMOTE, OP_TFREE, OP_COLD, OP_DEMOTE, OP_DROP, OP_FILL
  } op_t;

  function automatic logic [1:0] list_status(input logic [1:0] l);
    return l + 2'd1;
  endfunction

  function automatic logic [1:0] status_list(input logic [1:0] st);
    return st - 2'd1;
  endfunction

endpackage

>>> hw/rtl/clock_pro_page_replacement.sv
// CLOCK-Pro page replacement: a lookup scan over all slots, then list edits.
// Every access scans all slots; a hot hit then goes straight to its result, while other
// outcomes edit the lists; an eviction, a dropped test entry, a second chance (with or
// without a demotion) and a demotion from an empty cold list each add list steps.
// Words are taken one at a time, each the cycle after a result loads; stalls delay the load.
// Reset: synchronous; lists, hands, counts and slot valid bits clear at once.
module clock_pro_page_replacement (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cpr_pkg::DATA_W-1:0]  page_id,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  outcome,
  output logic                        victim_valid,
  output logic [cpr_pkg::DATA_W-1:0]  victim_page,
  output logic                        dropped_valid,
  output logic [cpr_pkg::DATA_W-1:0]  dropped_page,
  output logic [cpr_pkg::DATA_W-1:0]  access_count,
  output logic [cpr_pkg::DATA_W-1:0]  hit_count,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cpr_pkg::LIM_W-1:0]   resident_limit
);
  import cpr_pkg::*;

  state_t state, state_next;
  state_t ret;
  op_t    op;
  ptr_t   cur, idx, hit, tm, freemin, hand_c, hand_h;
  ptr_t   head [3];
  ptr_t   tail [3];
  ptr_t   cnt  [3];
  logic [1:0] tgt, oc;
  logic       hit_hot;
  page_t      id;
  logic [LIM_W-1:0]  limit;
  logic [DATA_W-1:0] acc, hits;
  logic       vic_v, drp_v;
  page_t      vic_p, drp_p;
  logic [SLOT_COUNT-1:0] valid;
  logic       vld_q;

  // Memory ports.
  logic [SLOT_BITS-1:0] raddr;
  logic pg_we, st_we, rf_we, nx_we, pv_we;
  logic [SLOT_BITS-1:0] pg_wa, st_wa, rf_wa, nx_wa, pv_wa;
  page_t pg_wd, pg_rd;
  logic [1:0] st_wd, st_rd;
  logic rf_wd, rf_rd;
  ptr_t nx_wd, nx_rd, pv_wd, pv_rd;

  cpr_ram #(.WIDTH(PAGE_BITS), .DEPTH(SLOT_COUNT)) u_page (
    .clk(clk), .we(pg_we), .waddr(pg_wa), .wdata(pg_wd), .raddr(raddr), .rdata(pg_rd));
  cpr_ram #(.WIDTH(2), .DEPTH(SLOT_COUNT)) u_stat (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(raddr), .rdata(st_rd));
  cpr_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_ref (
    .clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd), .raddr(raddr), .rdata(rf_rd));
  cpr_ram #(.WIDTH(PTR_W), .DEPTH(SLOT_COUNT)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(raddr), .rdata(nx_rd));
  cpr_ram #(.WIDTH(PTR_W), .DEPTH(SLOT_COUNT)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(raddr), .rdata(pv_rd));

  // Read data of a slot; an entry never written reads as free.
  logic [1:0] rd_st, rd_l;
  logic       rd_ref;
  ptr_t       pidx;
  logic       scan_proc;
  always_comb begin
    rd_st     = vld_q ? st_rd : ST_FREE;
    rd_ref    = vld_q & rf_rd;
    rd_l      = status_list(rd_st);
    pidx      = idx - ptr_t'(1);
    scan_proc = (state == S_SCAN) && (idx != '0);
    raddr     = (state == S_SCAN) ? idx[SLOT_BITS-1:0] : cur[SLOT_BITS-1:0];
  end

  // Hand starting points and the room check.
  logic [PTR_W:0] res_sum;
  logic room_ge;
  ptr_t cold_s, hot_s;
  always_comb begin
    res_sum = {1'b0, cnt[L_COLD]} + {1'b0, cnt[L_HOT]};
    room_ge = res_sum >= (PTR_W+1)'(limit);
    cold_s  = (hand_c == NIL) ? tail[L_COLD] : hand_c;
    hot_s   = (hand_h == NIL) ? tail[L_HOT] : hand_h;
  end

  logic unlink_en, free_en, out_load;
  always_comb begin
    unlink_en = (state == S_EXEC) && !((op == OP_COLD) && rd_ref);
    free_en   = unlink_en && ((op == OP_TFREE) || (op == OP_DROP));
    out_load  = (state == S_DONE) && (!out_valid || out_ready);
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_SCAN;
      S_SCAN: if (idx == ptr_t'(SLOT_COUNT)) state_next = S_DECIDE;
      S_DECIDE: begin
        if (hit != NIL) state_next = hit_hot ? S_DONE : S_RD;
        else state_next = (tm != NIL) ? S_RD : S_ROOM;
      end
      S_RD: state_next = S_EXEC;
      S_EXEC: begin
        case (op)
          OP_COLD: begin
            if (rd_ref) state_next = (cnt[L_HOT] != '0 && hot_s != NIL) ? S_RD : S_ROOM;
            else state_next = S_APP1;
          end
          OP_TFREE: state_next = S_ROOM;
          OP_DROP:  state_next = ret;
          default:  state_next = S_APP1;
        endcase
      end
      S_APP1: state_next = S_APP2;
      S_APP2: begin
        case (op)
          OP_COLD:   state_next = S_TRIM;
          OP_DEMOTE: state_next = S_ROOM;
          default:   state_next = S_DONE;
        endcase
      end
      S_ROOM: begin
        if (!room_ge) state_next = S_FILL;
        else if (cnt[L_COLD] != '0) state_next = (cold_s != NIL) ? S_RD : S_FILL;
        else state_next = (cnt[L_HOT] != '0 && hot_s != NIL) ? S_RD : S_FILL;
      end
      S_TRIM: begin
        if (cnt[L_TEST] > PTR_W'(limit) && head[L_TEST] != NIL) state_next = S_RD;
        else state_next = S_ROOM;
      end
      S_FILL: begin
        if (freemin != NIL) state_next = S_APP1;
        else state_next = (head[L_TEST] != NIL) ? S_RD : S_DONE;
      end
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory write controls.
  always_comb begin
    pg_we = 1'b0; pg_wa = freemin[SLOT_BITS-1:0]; pg_wd = id;
    rf_we = 1'b0; rf_wa = cur[SLOT_BITS-1:0];     rf_wd = 1'b0;
    st_we = 1'b0; st_wa = cur[SLOT_BITS-1:0];     st_wd = ST_FREE;
    nx_we = 1'b0; nx_wa = pv_rd[SLOT_BITS-1:0];   nx_wd = nx_rd;
    pv_we = 1'b0; pv_wa = nx_rd[SLOT_BITS-1:0];   pv_wd = pv_rd;
    case (state)
      S_DECIDE: begin
        rf_we = (hit != NIL);
        rf_wa = hit[SLOT_BITS-1:0];
        rf_wd = 1'b1;
      end
      S_EXEC: begin
        if ((op == OP_COLD) && rd_ref) begin
          rf_we = 1'b1;
          rf_wd = 1'b0;
        end
        if (unlink_en) begin
          nx_we = (pv_rd != NIL);
          pv_we = (nx_rd != NIL);
          st_we = free_en;
        end
      end
      S_APP1: begin
        st_we = 1'b1;
        st_wd = list_status(tgt);
        pv_we = 1'b1;
        pv_wa = cur[SLOT_BITS-1:0];
        pv_wd = tail[tgt];
        nx_we = (tail[tgt] != NIL);
        nx_wa = tail[tgt][SLOT_BITS-1:0];
        nx_wd = cur;
      end
      S_APP2: begin
        nx_we = 1'b1;
        nx_wa = cur[SLOT_BITS-1:0];
        nx_wd = NIL;
      end
      S_FILL: begin
        pg_we = (freemin != NIL);
        rf_we = (freemin != NIL);
        rf_wa = freemin[SLOT_BITS-1:0];
        rf_wd = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Control state and datapath registers.
  always_ff @(posedge clk) begin
    vld_q <= valid[raddr];
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      hand_c    <= NIL;
      hand_h    <= NIL;
      acc       <= '0;
      hits      <= '0;
      limit     <= LIM_W'(MAX_PAGES);
      out_valid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        head[k] <= NIL;
        tail[k] <= NIL;
        cnt[k]  <= '0;
      end
    end else begin
      state <= state_next;

      // Limit register, clamped to its legal range.
      if (cfg_valid) begin
        if (resident_limit == '0) limit <= LIM_W'(1);
        else if (resident_limit > LIM_W'(MAX_PAGES)) limit <= LIM_W'(MAX_PAGES);
        else limit <= resident_limit;
      end

      if (st_we) valid[st_wa] <= 1'b1;

      case (state)
        S_IDLE: if (in_valid) begin
          id      <= page_t'(page_id);
          if (acc != '1) acc <= acc + DATA_W'(1);
          idx     <= '0;
          hit     <= NIL;
          tm      <= NIL;
          freemin <= NIL;
          vic_v   <= 1'b0;
          vic_p   <= '0;
          drp_v   <= 1'b0;
          drp_p   <= '0;
        end
        // Pipelined lookup: address idx goes out while idx-1 comes back.
        S_SCAN: begin
          idx <= idx + ptr_t'(1);
          if (scan_proc) begin
            if (rd_st != ST_FREE && pg_rd == id) begin
              if (rd_st != ST_TEST && hit == NIL) begin
                hit     <= pidx;
                hit_hot <= (rd_st == ST_HOT);
              end
              if (rd_st == ST_TEST && tm == NIL) tm <= pidx;
            end
            if (rd_st == ST_FREE && freemin == NIL) freemin <= pidx;
          end
        end
        S_DECIDE: begin
          if (hit != NIL) begin
            if (hits != '1) hits <= hits + DATA_W'(1);
            oc  <= hit_hot ? OC_HOT_HIT : OC_COLD_HIT;
            cur <= hit;
            op  <= OP_PROMOTE;
            tgt <= L_HOT;
          end else begin
            oc  <= (tm != NIL) ? OC_TEST_HIT : OC_MISS;
            cur <= tm;
            op  <= OP_TFREE;
          end
        end
        S_EXEC: begin
          if (unlink_en) begin
            if (pv_rd == NIL) head[rd_l] <= nx_rd;
            if (nx_rd == NIL) tail[rd_l] <= pv_rd;
            if (cnt[rd_l] != '0) cnt[rd_l] <= cnt[rd_l] - ptr_t'(1);
            if (op != OP_COLD && op != OP_DEMOTE) begin
              if (rd_l == L_COLD && hand_c == cur) hand_c <= pv_rd;
              if (rd_l == L_HOT && hand_h == cur) hand_h <= pv_rd;
            end
          end
          if (free_en && cur < freemin) freemin <= cur;
          case (op)
            OP_COLD: begin
              hand_c <= pv_rd;
              if (rd_ref) begin
                cur <= hot_s;
                op  <= OP_DEMOTE;
              end else begin
                vic_v <= 1'b1;
                vic_p <= pg_rd;
                tgt   <= L_TEST;
              end
            end
            OP_DEMOTE: begin
              hand_h <= pv_rd;
              tgt    <= L_COLD;
            end
            OP_DROP: begin
              drp_v <= 1'b1;
              drp_p <= pg_rd;
            end
            default: ;
          endcase
        end
        // Append at the tail of the target list.
        S_APP1: begin
          if (tail[tgt] == NIL) head[tgt] <= cur;
          tail[tgt] <= cur;
          cnt[tgt]  <= cnt[tgt] + ptr_t'(1);
        end
        S_ROOM: begin
          if (cnt[L_COLD] != '0) begin
            cur <= cold_s;
            op  <= OP_COLD;
          end else begin
            cur <= hot_s;
            op  <= OP_DEMOTE;
          end
        end
        S_TRIM: begin
          cur <= head[L_TEST];
          op  <= OP_DROP;
          ret <= S_TRIM;
        end
        S_FILL: begin
          if (freemin != NIL) begin
            cur <= freemin;
            op  <= OP_FILL;
            tgt <= L_COLD;
          end else begin
            cur <= head[L_TEST];
            op  <= OP_DROP;
            ret <= S_FILL;
          end
        end
        default: ;
      endcase

      // Output register.
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (out_load) begin
        out_valid     <= 1'b1;
        outcome       <= oc;
        victim_valid  <= vic_v;
        victim_page   <= DATA_W'(vic_p);
        dropped_valid <= drp_v;
        dropped_page  <= DATA_W'(drp_p);
        access_count  <= acc;
        hit_count     <= hits;
      end
    end
  end

endmodule

>>> hw/rtl/cpr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first in program order; a same-edge read returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/cpr_checker.sv
// Port-level checker for the CLOCK-Pro replacement block, bound to its top.
// Depends on assert_macros.svh and cpr_pkg.
`include "assert_macros.svh"
module cpr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  outcome,
  input logic        victim_valid,
  input logic [31:0] victim_page,
  input logic        dropped_valid,
  input logic [31:0] dropped_page,
  input logic [31:0] access_count,
  input logic [31:0] hit_count
);
  import cpr_pkg::*;

  // An offered result word that reports a resident hit.
  logic res_hit;
  assign res_hit = out_valid && (outcome == OC_COLD_HIT || outcome == OC_HOT_HIT);

  // A stalled result word stays offered.
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // Page fields are zero unless their flag is set.
  `ASSERT_IMPL(a_victim_zero, out_valid, victim_valid || victim_page == '0)
  `ASSERT_IMPL(a_dropped_zero, out_valid, dropped_valid || dropped_page == '0)
  // A resident hit never evicts.
  `ASSERT_IMPL(a_hit_no_evict, res_hit, !victim_valid && !dropped_valid)
  // Hits never outnumber accesses.
  `ASSERT_IMPL(a_hits_le, out_valid, hit_count <= access_count)

endmodule

bind clock_pro_page_replacement cpr_checker u_cpr_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .outcome(outcome), .victim_valid(victim_valid), .victim_page(victim_page),
  .dropped_valid(dropped_valid), .dropped_page(dropped_page),
  .access_count(access_count), .hit_count(hit_count)
);
